[sv/indexed_list_insert_delete_unit_macros.svh]
// ---------------------------------------------------------------------------
// indexed list insert/delete unit - assertion macros
// Shared concurrent assertion shorthands for the list unit modules.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ILID_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ILID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ilid_pkg.sv]
// ---------------------------------------------------------------------------
// ilid_pkg
// Types, widths and codes shared by the indexed list unit modules.
// ---------------------------------------------------------------------------
package ilid_pkg;

  // default list capacity
  localparam int unsigned CAPACITY_DEF = 64;

  // field widths
  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned LEN_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // per-cycle action broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic                    rd_en;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  // command transaction
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } item_t;

  // result transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
  } result_t;

endpackage

[sv/ilid_cell.sv]
// ---------------------------------------------------------------------------
// ilid_cell
// One list slot: holds a value, shifts from a neighbor on insert or delete,
// and presents its value on the read bus when addressed.
// ---------------------------------------------------------------------------
module ilid_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                            clk_i,
  input  ilid_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [ilid_pkg::VAL_W-1:0] left_i,
  input  logic signed [ilid_pkg::VAL_W-1:0] right_i,
  output logic signed [ilid_pkg::VAL_W-1:0] data_o,
  output logic signed [ilid_pkg::VAL_W-1:0] rd_o
);

  localparam logic [ilid_pkg::POS_W-1:0] IdxPos = ilid_pkg::POS_W'(Index);

  logic signed [ilid_pkg::VAL_W-1:0] data_d, data_q;
  logic signed [ilid_pkg::VAL_W-1:0] rd_d, rd_q;

  // slot update: shift up on insert, shift down on delete
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      ilid_pkg::CELL_INSERT: begin
        if (IdxPos > ctrl_i.pos) begin
          data_d = left_i;
        end else if (IdxPos == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      ilid_pkg::CELL_DELETE: begin
        if (IdxPos >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // masked read tap, zero unless this slot is addressed
  assign rd_d = (ctrl_i.rd_en && (ctrl_i.pos == IdxPos)) ? data_q : '0;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

[sv/ilid_or_tree.sv]
// ---------------------------------------------------------------------------
// ilid_or_tree
// Collects the masked read taps of all cells: groups of eight are OR-ed
// into registers, then the group results are OR-ed into one word.
// ---------------------------------------------------------------------------
module ilid_or_tree #(
  parameter int unsigned N = ilid_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic signed [ilid_pkg::VAL_W-1:0] tap_i [N],
  output logic signed [ilid_pkg::VAL_W-1:0] word_o
);

  localparam int unsigned Group = 8;
  localparam int unsigned NumGroups = (N + Group - 1) / Group;

  logic signed [ilid_pkg::VAL_W-1:0] pad [NumGroups*Group];
  logic signed [ilid_pkg::VAL_W-1:0] group_q [NumGroups];

  // pad the tap row to whole groups
  for (genvar i = 0; i < NumGroups * Group; i++) begin : g_pad
    if (i < N) begin : g_tap
      assign pad[i] = tap_i[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  // first level, registered
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    always_ff @(posedge clk_i) begin
      group_q[g] <= pad[g*Group+0] | pad[g*Group+1] | pad[g*Group+2] | pad[g*Group+3]
                  | pad[g*Group+4] | pad[g*Group+5] | pad[g*Group+6] | pad[g*Group+7];
    end
  end

  // second level
  always_comb begin
    word_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      word_o = word_o | group_q[g];
    end
  end

endmodule

[sv/indexed_list_insert_delete_unit.sv]
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of up to CAPACITY signed values kept in a row of cells;
// read, insert at head/tail/position and delete at position.
// ---------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------
//  command   | start / busy     | item_i   (cmd, position, value_in)
//  result    | done_o strobe    | result_o (value_out, status, length)
//
//  A command is taken in every cycle; busy stays low. Inserts and deletes
//  shift the cells from the position up in the cycle of acceptance, so the
//  next command sees the updated list. The result passes the cell read tap
//  and the two-level OR collection of the read value, with a matching valid
//  chain for the strobe. Reset clears the entry count and the result valid
//  flags; cell contents are not cleared. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
`include "indexed_list_insert_delete_unit_macros.svh"

module indexed_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ilid_pkg::item_t   item_i,
  output logic              done_o,
  output ilid_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  logic                   accept;
  logic                   full;
  logic [ilid_pkg::POS_W-1:0] cnt_pos;
  logic [CntW-1:0]        cnt_d, cnt_q;
  ilid_pkg::cell_ctrl_t   ctrl;
  logic [ilid_pkg::ST_W-1:0] stat;

  logic signed [ilid_pkg::VAL_W-1:0] cell_data [CAPACITY];
  logic signed [ilid_pkg::VAL_W-1:0] cell_rd   [CAPACITY];
  logic signed [ilid_pkg::VAL_W-1:0] rd_word;

  // result pipeline, aligned with the read collection
  logic                      p1_vld_q, p2_vld_q, done_q;
  logic [ilid_pkg::ST_W-1:0] p1_st_q, p2_st_q;
  logic [ilid_pkg::LEN_W-1:0] p1_len_q, p2_len_q;
  ilid_pkg::result_t         res_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = (cnt_q == CntFull);
  assign cnt_pos = ilid_pkg::POS_W'(cnt_q);

  // command decode into a cell action and a status
  always_comb begin
    ctrl.op    = ilid_pkg::CELL_HOLD;
    ctrl.rd_en = 1'b0;
    ctrl.pos   = item_i.position;
    ctrl.value = item_i.value_in;
    stat       = ilid_pkg::ST_DONE;
    cnt_d      = cnt_q;
    if (accept) begin
      case (item_i.cmd)
        ilid_pkg::CMD_READ: begin
          if (item_i.position < cnt_pos) begin
            ctrl.rd_en = 1'b1;
          end else begin
            stat = ilid_pkg::ST_RANGE;
          end
        end
        ilid_pkg::CMD_HEAD: begin
          ctrl.pos = '0;
          if (full) begin
            stat = ilid_pkg::ST_FULL;
          end else begin
            ctrl.op = ilid_pkg::CELL_INSERT;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        ilid_pkg::CMD_TAIL: begin
          ctrl.pos = cnt_pos;
          if (full) begin
            stat = ilid_pkg::ST_FULL;
          end else begin
            ctrl.op = ilid_pkg::CELL_INSERT;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        ilid_pkg::CMD_INSERT: begin
          if (item_i.position > cnt_pos) begin
            stat = ilid_pkg::ST_RANGE;
          end else if (full) begin
            stat = ilid_pkg::ST_FULL;
          end else begin
            ctrl.op = ilid_pkg::CELL_INSERT;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        ilid_pkg::CMD_DELETE: begin
          if (item_i.position < cnt_pos) begin
            ctrl.op = ilid_pkg::CELL_DELETE;
            cnt_d   = cnt_q - 1'b1;
          end else begin
            stat = ilid_pkg::ST_RANGE;
          end
        end
        default: stat = ilid_pkg::ST_DONE;
      endcase
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // cell row, each cell linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ilid_pkg::VAL_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = ctrl.value;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    ilid_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // read value collection
  ilid_or_tree #(
    .N (CAPACITY)
  ) u_or_tree (
    .clk_i  (clk_i),
    .tap_i  (cell_rd),
    .word_o (rd_word)
  );

  // result pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p1_vld_q <= accept;
      p2_vld_q <= p1_vld_q;
      done_q   <= p2_vld_q;
    end
  end

  // result pipeline payload
  always_ff @(posedge clk_i) begin
    p1_st_q         <= stat;
    p1_len_q        <= ilid_pkg::LEN_W'(cnt_d);
    p2_st_q         <= p1_st_q;
    p2_len_q        <= p1_len_q;
    res_q.value_out <= rd_word;
    res_q.status    <= p2_st_q;
    res_q.length    <= p2_len_q;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  `ILID_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntFull, "entry count over capacity")
  `ILID_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && (result_o.status != ilid_pkg::ST_DONE), result_o.value_out == '0, "nonzero value on failed command")
  `ILID_ASSERT_NEXT(a_full_drop, clk_i, rst_ni, accept && full && (ctrl.op == ilid_pkg::CELL_INSERT), 1'b0, "insert applied to full list")
  `ILID_ASSERT_NEXT(a_del_count, clk_i, rst_ni, ctrl.op == ilid_pkg::CELL_DELETE, cnt_q == $past(cnt_q) - 1'b1, "delete did not shrink count")
  `ILID_ASSERT_IMPL(a_done_lat, clk_i, rst_ni, done_o, $past(accept, 3), "result without command")

endmodule

[tb/tb_indexed_list_insert_delete_unit.sv]
// ---------------------------------------------------------------------------
// tb_indexed_list_insert_delete_unit
// Self-checking bench for the indexed list unit. A behavioral list model
// predicts value, status and length for every accepted command. Directed
// tests cover empty and full lists, range errors and unused codes; random
// traffic then grows, shrinks and churns the list with random idle gaps.
// ---------------------------------------------------------------------------
module tb_indexed_list_insert_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP = ilid_pkg::CAPACITY_DEF;
  localparam int unsigned GAP_MAX  = 13;
  localparam int unsigned TAIL_CYC = 8;

  // codes the block must treat as no-ops
  localparam logic [ilid_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [ilid_pkg::CMD_W-1:0] CMD_UNUSED_MD = 3'd6;
  localparam logic [ilid_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [ilid_pkg::POS_W-1:0] POS_LAST = '1;
  localparam logic signed [ilid_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ilid_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ilid_pkg::item_t   item_i;
  logic              done_o;
  ilid_pkg::result_t result_o;

  // list model and pending results
  logic signed [ilid_pkg::VAL_W-1:0] list_vals[$];
  ilid_pkg::result_t                 pending_results[$];
  int unsigned                       fail_count;
  int unsigned                       gap_lim;

  indexed_list_insert_delete_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // list behavior: apply one command, return its result
  function automatic ilid_pkg::result_t apply_command(ilid_pkg::item_t it);
    ilid_pkg::result_t r;
    int unsigned       cnt;
    int unsigned       pos;
    cnt         = list_vals.size();
    pos         = it.position;
    r.value_out = '0;
    r.status    = ilid_pkg::ST_DONE;
    case (it.cmd)
      ilid_pkg::CMD_READ: begin
        if (pos < cnt) r.value_out = list_vals[pos];
        else r.status = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::CMD_HEAD: begin
        if (cnt >= LIST_CAP) r.status = ilid_pkg::ST_FULL;
        else list_vals.push_front(it.value_in);
      end
      ilid_pkg::CMD_TAIL: begin
        if (cnt >= LIST_CAP) r.status = ilid_pkg::ST_FULL;
        else list_vals.push_back(it.value_in);
      end
      ilid_pkg::CMD_INSERT: begin
        // range check wins over the full check
        if (pos > cnt) r.status = ilid_pkg::ST_RANGE;
        else if (cnt >= LIST_CAP) r.status = ilid_pkg::ST_FULL;
        else list_vals.insert(pos, it.value_in);
      end
      ilid_pkg::CMD_DELETE: begin
        if (pos < cnt) list_vals.delete(pos);
        else r.status = ilid_pkg::ST_RANGE;
      end
      default: begin
      end
    endcase
    r.length = ilid_pkg::LEN_W'(list_vals.size());
    return r;
  endfunction

  // send one command transaction, then idle for a random gap
  task automatic send_command(ilid_pkg::item_t it);
    int unsigned gap;
    start  <= 1'b1;
    item_i <= it;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    pending_results.push_back(apply_command(it));
    gap = $urandom_range(0, gap_lim);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(logic [ilid_pkg::CMD_W-1:0] cmd,
                             logic [ilid_pkg::POS_W-1:0] pos,
                             logic signed [ilid_pkg::VAL_W-1:0] val);
    ilid_pkg::item_t it;
    it.cmd      = cmd;
    it.position = pos;
    it.value_in = val;
    send_command(it);
  endtask

  // hold off until every pending result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [ilid_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // random position, mostly near the valid range
  function automatic logic [ilid_pkg::POS_W-1:0] rand_position();
    int unsigned cnt;
    cnt = list_vals.size();
    case ($urandom_range(0, 19))
      0, 1:    return ilid_pkg::POS_W'($urandom());
      2:       return POS_LAST;
      3, 4, 5: return ilid_pkg::POS_W'(cnt + $urandom_range(0, 2));
      default: return (cnt == 0) ? '0 : ilid_pkg::POS_W'($urandom_range(0, cnt - 1));
    endcase
  endfunction

  // random command, biased toward inserts by grow_pct
  function automatic ilid_pkg::item_t rand_item(int unsigned grow_pct);
    ilid_pkg::item_t it;
    int unsigned     roll;
    roll        = $urandom_range(0, 99);
    it.position = rand_position();
    it.value_in = rand_value();
    if (roll < 4) begin
      it.cmd = ilid_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end else if (roll < 24) begin
      it.cmd = ilid_pkg::CMD_READ;
    end else if (roll < 24 + (grow_pct * 76) / 100) begin
      case ($urandom_range(0, 2))
        0:       it.cmd = ilid_pkg::CMD_HEAD;
        1:       it.cmd = ilid_pkg::CMD_TAIL;
        default: it.cmd = ilid_pkg::CMD_INSERT;
      endcase
    end else begin
      it.cmd = ilid_pkg::CMD_DELETE;
    end
    return it;
  endfunction

  // edge values, every command and the range cases on a short list
  task automatic test_boundary_values();
    gap_lim = GAP_MAX;
    send_fields(ilid_pkg::CMD_READ,   '0,       '0);
    send_fields(ilid_pkg::CMD_DELETE, '0,       '0);
    send_fields(ilid_pkg::CMD_INSERT, 16'd1,    VAL_MAX);
    send_fields(ilid_pkg::CMD_INSERT, POS_LAST, VAL_MIN);
    send_fields(ilid_pkg::CMD_INSERT, '0,       VAL_MAX);
    send_fields(ilid_pkg::CMD_HEAD,   POS_LAST, VAL_MIN);
    send_fields(ilid_pkg::CMD_TAIL,   POS_LAST, '1);
    send_fields(ilid_pkg::CMD_TAIL,   '0,       '0);
    send_fields(ilid_pkg::CMD_INSERT, 16'd2,    32'sh5555_5555);
    send_fields(ilid_pkg::CMD_INSERT, 16'd5,    32'sh2aaa_aaaa);
    send_fields(ilid_pkg::CMD_READ,   '0,       '1);
    send_fields(ilid_pkg::CMD_READ,   16'd5,    '0);
    send_fields(ilid_pkg::CMD_READ,   16'd6,    '0);
    send_fields(ilid_pkg::CMD_READ,   POS_LAST, '0);
    send_fields(CMD_UNUSED_LO, POS_LAST, '1);
    send_fields(CMD_UNUSED_MD, '0,       VAL_MIN);
    send_fields(CMD_UNUSED_HI, 16'h5a5a, VAL_MAX);
    send_fields(ilid_pkg::CMD_DELETE, POS_LAST, '1);
    send_fields(ilid_pkg::CMD_DELETE, 16'd6,    '0);
    send_fields(ilid_pkg::CMD_DELETE, 16'd5,    '0);
    send_fields(ilid_pkg::CMD_DELETE, 16'd2,    '0);
    send_fields(ilid_pkg::CMD_DELETE, '0,       '0);
    send_fields(ilid_pkg::CMD_READ,   16'd1,    '0);
  endtask

  // fill to capacity, hit the full and range cases, then empty it
  task automatic test_full_list();
    gap_lim = 0;
    while (list_vals.size() < LIST_CAP) begin
      send_fields(ilid_pkg::CMD_W'($urandom_range(ilid_pkg::CMD_HEAD, ilid_pkg::CMD_INSERT)),
                  ilid_pkg::POS_W'($urandom_range(0, list_vals.size())), rand_value());
    end
    gap_lim = GAP_MAX;
    send_fields(ilid_pkg::CMD_HEAD,   '0,                            VAL_MAX);
    send_fields(ilid_pkg::CMD_TAIL,   '0,                            VAL_MIN);
    send_fields(ilid_pkg::CMD_INSERT, ilid_pkg::POS_W'(LIST_CAP),     '1);
    send_fields(ilid_pkg::CMD_INSERT, '0,                            '1);
    send_fields(ilid_pkg::CMD_INSERT, ilid_pkg::POS_W'(LIST_CAP + 1), '1);
    send_fields(ilid_pkg::CMD_INSERT, POS_LAST,                      '1);
    send_fields(ilid_pkg::CMD_READ,   ilid_pkg::POS_W'(LIST_CAP - 1), '0);
    send_fields(ilid_pkg::CMD_READ,   ilid_pkg::POS_W'(LIST_CAP),     '0);
    send_fields(ilid_pkg::CMD_DELETE, ilid_pkg::POS_W'(LIST_CAP),     '0);
    send_fields(ilid_pkg::CMD_DELETE, ilid_pkg::POS_W'(LIST_CAP - 1), '0);
    send_fields(ilid_pkg::CMD_INSERT, ilid_pkg::POS_W'(LIST_CAP - 1), VAL_MAX);
    wait_results_drained();
    while (list_vals.size() > 0) begin
      send_fields(ilid_pkg::CMD_DELETE,
                  ilid_pkg::POS_W'($urandom_range(0, list_vals.size() - 1)), '0);
    end
    send_fields(ilid_pkg::CMD_DELETE, '0, '0);
  endtask

  // random traffic in phases that grow, shrink and churn the list
  task automatic test_random_traffic();
    int unsigned grow_pct;
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 3)
        0:       grow_pct = 80;
        1:       grow_pct = 20;
        default: grow_pct = 50;
      endcase
      gap_lim = (ph % 4 == 1) ? 0 : GAP_MAX;
      for (int n = 0; n < 135; n++) send_command(rand_item(grow_pct));
      if (ph % 2 == 1) wait_results_drained();
    end
  endtask

  // result checker
  always @(negedge clk_i) begin
    ilid_pkg::result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.value_out !== want.value_out) begin
          $error("value_out: expected %0d, actual %0d", want.value_out, result_o.value_out);
          fail_count++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_o.status);
          fail_count++;
        end
        if (result_o.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, result_o.length);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    fail_count = 0;
    gap_lim    = GAP_MAX;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundary_values();
    test_full_list();
    test_random_traffic();
    wait_results_drained();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
